// File: src/voice_slot_allocator_envelope_macros.svh
// Assertion helpers for the voice slot allocator.
`ifndef VOICE_SLOT_ALLOCATOR_ENVELOPE_MACROS_SVH
`define VOICE_SLOT_ALLOCATOR_ENVELOPE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, masked during reset.
`define VSA_AST_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("voice allocator assertion failed");

// Next-cycle implication, masked during reset.
`define VSA_AST_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("voice allocator assertion failed");

`else

`define VSA_AST_IMP(lbl, clk, rstn, ante, cons)
`define VSA_AST_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: src/vsa_pkg.sv
package vsa_pkg;

	localparam int VOICES      = 4;
	localparam int LEVEL_LIMIT = 256;

	localparam int CNT_W = $clog2(VOICES + 1);

	localparam logic [8:0] LEVEL_TOP = 9'(LEVEL_LIMIT - 1);
	localparam logic [8:0] DECAY_ONE = 9'd256;

	typedef enum logic [1:0] {
		OP_PLAY    = 2'd0,
		OP_RELEASE = 2'd1,
		OP_TICK    = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic {
		REG_ATTACK  = 1'b0,
		REG_RELEASE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] pitch_a;
		logic [15:0] pitch_b;
		logic [15:0] pitch_c;
		logic [7:0]  level;
		logic        gate;
		logic [7:0]  key;
	} slot_t;

	typedef struct packed {
		logic       valid;
		op_t        op;
		slot_t      voice;
		logic [7:0] key;
		logic [7:0] attack_step;
		logic [7:0] release_factor;
	} cmd_t;

	function automatic logic [2:0] sat_count(input logic [CNT_W-1:0] c);
		logic [CNT_W+2:0] wide;
		wide = {3'b000, c};
		return (wide > (CNT_W+3)'(7)) ? 3'd7 : wide[2:0];
	endfunction

endpackage

// File: src/vsa_cell.sv
module vsa_cell import vsa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  slot_t            upper,
	input  logic             sel,
	input  logic             none_free,
	input  logic             found_in,
	output logic             found_out,
	input  logic [CNT_W-1:0] cnt_in,
	output logic [CNT_W-1:0] cnt_out,
	input  slot_t            rd_in,
	output slot_t            rd_out,
	output slot_t            slot
);

	slot_t       slot_q;
	slot_t       slot_d;
	logic        free;
	logic        claim;
	logic [8:0]  attack_sum;
	logic [8:0]  keep;
	logic [16:0] decay_prod;

	assign free      = (slot_q.level == 8'd0) && !slot_q.gate;
	assign claim     = free && !found_in;
	assign found_out = found_in | free;
	assign cnt_out   = cnt_in + {{(CNT_W-1){1'b0}}, !free};
	assign rd_out    = sel ? slot_q : rd_in;
	assign slot      = slot_q;

	assign attack_sum = {1'b0, slot_q.level} + {1'b0, cmd.attack_step};
	assign keep       = DECAY_ONE - {1'b0, cmd.release_factor};
	assign decay_prod = {9'd0, slot_q.level} * {8'd0, keep};

	always_comb begin
		slot_d = slot_q;
		unique case (cmd.op)
			OP_PLAY: begin
				// lowest free slot takes the voice; if all are busy, shift down
				if (claim) begin
					slot_d = cmd.voice;
				end else if (none_free) begin
					slot_d = upper;
				end
			end
			OP_RELEASE: begin
				if (slot_q.gate && (slot_q.key == cmd.key)) begin
					slot_d.gate = 1'b0;
				end
			end
			OP_TICK: begin
				if (slot_q.gate) begin
					slot_d.level = (attack_sum < LEVEL_TOP) ? attack_sum[7:0] : LEVEL_TOP[7:0];
				end else begin
					slot_d.level = decay_prod[15:8];
				end
			end
			OP_READ: begin
				slot_d = slot_q;
			end
			default: begin
				slot_d = slot_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.valid) begin
			slot_q <= slot_d;
		end
	end

endmodule

// File: src/voice_slot_allocator_envelope.sv
// Channel   Handshake           Contents
// ------    ---------           --------
// command   start / busy        op, pitch_a/b/c, key_id, slot_index
// result    done (one cycle)    read_pitch_a/b/c, read_level/gate/key, voices_active
// config    cfg_we              cfg_index, cfg_wdata
//
// One word per cycle: a command is taken at any edge with start high, and its
// result shows on done in the cycle after. The slot row updates at that edge,
// so the result reads the state the command left behind.
// busy stays low: the cell row never needs a wait state for any command.
// Reset clears all slots (every slot free) and loads the default rates.
// The receiver cannot stall; a result not taken in its cycle is gone.

`include "voice_slot_allocator_envelope_macros.svh"

module voice_slot_allocator_envelope import vsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [15:0] pitch_a,
	input  logic [15:0] pitch_b,
	input  logic [15:0] pitch_c,
	input  logic [7:0]  key_id,
	input  logic [1:0]  slot_index,
	output logic        done,
	output logic [15:0] read_pitch_a,
	output logic [15:0] read_pitch_b,
	output logic [15:0] read_pitch_c,
	output logic [7:0]  read_level,
	output logic        read_gate,
	output logic [7:0]  read_key,
	output logic [2:0]  voices_active,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);

	logic       done_q;
	op_t        op_q;
	logic [1:0] idx_q;
	logic [7:0] attack_q;
	logic [7:0] release_q;

	cmd_t             cmd;
	slot_t            rd_word;
	slot_t            upper_chain [VOICES];
	slot_t            slot_chain  [VOICES];
	slot_t            rd_chain    [VOICES+1];
	logic             found_chain [VOICES+1];
	logic [CNT_W-1:0] cnt_chain   [VOICES+1];
	logic             sel         [VOICES];
	logic             none_free;

	// no wait state: the cell row finishes each command without stalling
	assign busy = 1'b0;

	// assemble the command broadcast to every cell
	always_comb begin
		cmd.valid          = start && !busy;
		cmd.op             = op_t'(op);
		cmd.voice.pitch_a  = pitch_a;
		cmd.voice.pitch_b  = pitch_b;
		cmd.voice.pitch_c  = pitch_c;
		cmd.voice.level    = 8'd1;
		cmd.voice.gate     = 1'b1;
		cmd.voice.key      = key_id;
		cmd.key            = key_id;
		cmd.attack_step    = attack_q;
		cmd.release_factor = release_q;
	end

	// chain heads: nothing found below slot 0, no count, no read data
	assign found_chain[0] = 1'b0;
	assign cnt_chain[0]   = '0;
	assign rd_chain[0]    = '0;
	// all busy means every cell loads its upper neighbour; the top one loads the new voice
	assign none_free      = !found_chain[VOICES];

	genvar gi;
	generate
		for (gi = 0; gi < VOICES; gi++) begin : g_cell
			if (gi == VOICES - 1) begin : g_top
				assign upper_chain[gi] = cmd.voice;
			end else begin : g_mid
				assign upper_chain[gi] = slot_chain[gi+1];
			end

			assign sel[gi] = (32'(idx_q) == gi);

			vsa_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.upper     (upper_chain[gi]),
				.sel       (sel[gi]),
				.none_free (none_free),
				.found_in  (found_chain[gi]),
				.found_out (found_chain[gi+1]),
				.cnt_in    (cnt_chain[gi]),
				.cnt_out   (cnt_chain[gi+1]),
				.rd_in     (rd_chain[gi]),
				.rd_out    (rd_chain[gi+1]),
				.slot      (slot_chain[gi])
			);
		end
	endgenerate

	// hold the command kind and slot index for the result cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			op_q   <= OP_PLAY;
			idx_q  <= 2'd0;
		end else begin
			done_q <= start && !busy;
			if (start && !busy) begin
				op_q  <= op_t'(op);
				idx_q <= slot_index;
			end
		end
	end

	// rate registers, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= 8'd12;
			release_q <= 8'd3;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ATTACK:  attack_q  <= cfg_wdata;
				REG_RELEASE: release_q <= cfg_wdata;
				default:     attack_q  <= attack_q;
			endcase
		end
	end

	// drop the slot fields unless the word is a read; the two-bit index always names a slot of the row
	assign rd_word = (op_q == OP_READ) ? rd_chain[VOICES] : '0;

	assign done          = done_q;
	assign read_pitch_a  = rd_word.pitch_a;
	assign read_pitch_b  = rd_word.pitch_b;
	assign read_pitch_c  = rd_word.pitch_c;
	assign read_level    = rd_word.level;
	assign read_gate     = rd_word.gate;
	assign read_key      = rd_word.key;
	assign voices_active = sat_count(cnt_chain[VOICES]);

	`VSA_AST_NXT(a_done_follows_start, clk, arst_n, start && !busy, done)
	`VSA_AST_NXT(a_no_spurious_done, clk, arst_n, !(start && !busy), !done)
	`VSA_AST_IMP(a_play_holds, clk, arst_n, done && (op_q == OP_PLAY), voices_active != '0)
	`VSA_AST_IMP(a_quiet_fields, clk, arst_n, done && (op_q != OP_READ), rd_word == '0)
	`VSA_AST_IMP(a_count_bound, clk, arst_n, 1'b1, cnt_chain[VOICES] <= CNT_W'(VOICES))

endmodule

// File: test/voice_slot_allocator_envelope_tb.sv
`timescale 1ns / 100ps

module voice_slot_allocator_envelope_tb;
	import vsa_pkg::*;

	// One result word as the block reports it.
	typedef struct packed {
		logic [15:0] pitch_a;
		logic [15:0] pitch_b;
		logic [15:0] pitch_c;
		logic [7:0]  level;
		logic        gate;
		logic [7:0]  key;
		logic [2:0]  active;
	} voice_report_t;

	// One row of the directed table; pinned rows carry a hand-written result.
	typedef struct {
		op_t           op;
		logic [15:0]   pitch_a;
		logic [15:0]   pitch_b;
		logic [15:0]   pitch_c;
		logic [7:0]    key;
		logic [1:0]    slot;
		logic          pinned;
		voice_report_t want;
	} stim_row_t;

	localparam int DECAY_SCALE = 256;
	localparam int PHASES      = 5;
	localparam int RAND_WORDS  = 390;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        start         = 1'b0;
	logic        busy;
	logic [1:0]  op            = '0;
	logic [15:0] pitch_a       = '0;
	logic [15:0] pitch_b       = '0;
	logic [15:0] pitch_c       = '0;
	logic [7:0]  key_id        = '0;
	logic [1:0]  slot_index    = '0;
	logic        done;
	logic [15:0] read_pitch_a;
	logic [15:0] read_pitch_b;
	logic [15:0] read_pitch_c;
	logic [7:0]  read_level;
	logic        read_gate;
	logic [7:0]  read_key;
	logic [2:0]  voices_active;
	logic        cfg_we        = 1'b0;
	logic        cfg_index     = 1'b0;
	logic [7:0]  cfg_wdata     = '0;

	// Testbench-side companions of the command word: a pinned expectation
	// rides along with the word it belongs to.
	logic          pin_valid = 1'b0;
	voice_report_t pin_word  = '0;

	// Predictor state: its own copy of the slot row and the two rates.
	slot_t      voice_bank [VOICES];
	logic [7:0] attack_rate = 8'd12;
	logic [7:0] decay_rate  = 8'd3;

	voice_report_t reports_due [$];
	int unsigned   fails = 0;

	// Driver bookkeeping for shaping the random stream.
	logic [7:0] recent_keys [8];
	int         key_ptr   = 0;
	int         calm_left = 0;
	int         tick_run  = 0;

	stim_row_t  dir_table [$];

	voice_slot_allocator_envelope i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.pitch_a       (pitch_a),
		.pitch_b       (pitch_b),
		.pitch_c       (pitch_c),
		.key_id        (key_id),
		.slot_index    (slot_index),
		.done          (done),
		.read_pitch_a  (read_pitch_a),
		.read_pitch_b  (read_pitch_b),
		.read_pitch_c  (read_pitch_c),
		.read_level    (read_level),
		.read_gate     (read_gate),
		.read_key      (read_key),
		.voices_active (voices_active),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic bit slot_is_free(int s);
		return voice_bank[s].level == 8'd0 && voice_bank[s].gate == 1'b0;
	endfunction

	// Apply one command to the predicted slot row and return the word it
	// should produce.
	function automatic voice_report_t advance_voices(op_t c_op, logic [15:0] a,
			logic [15:0] b, logic [15:0] c, logic [7:0] k, logic [1:0] s);
		voice_report_t rep;
		int            target;
		bit            found;
		int            lv;
		int            n_held;
		rep    = '0;
		target = VOICES - 1;
		found  = 1'b0;
		n_held = 0;
		case (c_op)
			OP_PLAY: begin
				for (int i = 0; i < VOICES; i++) begin
					if (!found && slot_is_free(i)) begin
						target = i;
						found  = 1'b1;
					end
				end
				// No free slot: drop slot 0 and shift the rest down.
				if (!found) begin
					for (int i = 0; i < VOICES - 1; i++)
						voice_bank[i] = voice_bank[i + 1];
				end
				voice_bank[target].pitch_a = a;
				voice_bank[target].pitch_b = b;
				voice_bank[target].pitch_c = c;
				voice_bank[target].level   = 8'd1;
				voice_bank[target].gate    = 1'b1;
				voice_bank[target].key     = k;
			end
			OP_RELEASE: begin
				for (int i = 0; i < VOICES; i++) begin
					if (voice_bank[i].gate && voice_bank[i].key == k)
						voice_bank[i].gate = 1'b0;
				end
			end
			OP_TICK: begin
				for (int i = 0; i < VOICES; i++) begin
					lv = int'(voice_bank[i].level);
					if (voice_bank[i].gate) begin
						// Attack saturates one below the level limit.
						if (lv + int'(attack_rate) < LEVEL_LIMIT - 1)
							lv = lv + int'(attack_rate);
						else
							lv = LEVEL_LIMIT - 1;
					end else begin
						// Release decays with floor; zero stays zero.
						lv = (lv * (DECAY_SCALE - int'(decay_rate))) / DECAY_SCALE;
					end
					voice_bank[i].level = 8'(lv);
				end
			end
			default: begin
				if (int'(s) < VOICES) begin
					rep.pitch_a = voice_bank[s].pitch_a;
					rep.pitch_b = voice_bank[s].pitch_b;
					rep.pitch_c = voice_bank[s].pitch_c;
					rep.level   = voice_bank[s].level;
					rep.gate    = voice_bank[s].gate;
					rep.key     = voice_bank[s].key;
				end
			end
		endcase
		for (int i = 0; i < VOICES; i++) begin
			if (!slot_is_free(i))
				n_held++;
		end
		rep.active = (n_held > 7) ? 3'd7 : 3'(n_held);
		return rep;
	endfunction

	function automatic string show_report(voice_report_t r);
		return $sformatf("pa=%h pb=%h pc=%h lvl=%h gate=%b key=%h act=%0d",
			r.pitch_a, r.pitch_b, r.pitch_c, r.level, r.gate, r.key, r.active);
	endfunction

	// Expected word for a non-read command: slot fields zero.
	function automatic voice_report_t quiet(logic [2:0] n);
		voice_report_t r;
		r        = '0;
		r.active = n;
		return r;
	endfunction

	function automatic voice_report_t seen(logic [15:0] a, logic [15:0] b,
			logic [15:0] c, logic [7:0] lvl, logic g, logic [7:0] k, logic [2:0] n);
		voice_report_t r;
		r.pitch_a = a;
		r.pitch_b = b;
		r.pitch_c = c;
		r.level   = lvl;
		r.gate    = g;
		r.key     = k;
		r.active  = n;
		return r;
	endfunction

	// Monitor: check the word on done first (it belongs to the command taken
	// at the previous edge), then track rate writes, then predict the command
	// taken at this edge.
	always @(posedge clk) begin
		voice_report_t got;
		voice_report_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				got = {read_pitch_a, read_pitch_b, read_pitch_c, read_level,
					read_gate, read_key, voices_active};
				if (reports_due.size() == 0) begin
					if (fails < 10)
						$display("%0t: result word with nothing due: %s", $realtime,
							show_report(got));
					fails++;
				end else begin
					want = reports_due.pop_front();
					if (got !== want) begin
						if (fails < 10) begin
							$display("%0t: mismatch", $realtime);
							$display("  expected %s", show_report(want));
							$display("  actual   %s", show_report(got));
						end
						fails++;
					end
				end
			end
			if (cfg_we === 1'b1) begin
				case (reg_idx_t'(cfg_index))
					REG_ATTACK:  attack_rate = cfg_wdata;
					REG_RELEASE: decay_rate  = cfg_wdata;
					default: ;
				endcase
			end
			if (start === 1'b1 && busy === 1'b0) begin
				want = advance_voices(op_t'(op), pitch_a, pitch_b, pitch_c, key_id,
					slot_index);
				// A pinned row overrides the prediction; the predictor still
				// advances so that later rows stay in step.
				reports_due.push_back(pin_valid ? pin_word : want);
			end
		end
	end

	// Present one command word and hold it until the block takes it.
	task automatic send_word(op_t c_op, logic [15:0] a, logic [15:0] b,
			logic [15:0] c, logic [7:0] k, logic [1:0] s, logic pinned,
			voice_report_t want);
		start      <= 1'b1;
		op         <= c_op;
		pitch_a    <= a;
		pitch_b    <= b;
		pitch_c    <= c;
		key_id     <= k;
		slot_index <= s;
		pin_valid  <= pinned;
		pin_word   <= want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Idle the sender for a random stretch; skip while a calm burst runs.
	task automatic hold_off(int pct);
		int gap;
		gap = 0;
		if (calm_left > 0) begin
			calm_left--;
		end else begin
			while (gap < 20 && $urandom_range(99) < pct)
				gap++;
			if ($urandom_range(59) == 0)
				calm_left = $urandom_range(40, 10);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lower start and wait until every due word has come back.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_rates(logic [7:0] attack, logic [7:0] decay);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ATTACK;
		cfg_wdata <= attack;
		@(posedge clk);
		cfg_index <= REG_RELEASE;
		cfg_wdata <= decay;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Random stream: plays, releases of keys that were played, runs of
	// ticks long enough to saturate or drain levels, and reads; a share of
	// releases names an arbitrary key as noise.
	task automatic run_random(int count, int pct);
		op_t        c_op;
		logic [7:0] k;
		int         r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (tick_run > 0) begin
				c_op = OP_TICK;
				tick_run--;
			end else if (r < 30) begin
				c_op = OP_PLAY;
			end else if (r < 50) begin
				c_op = OP_RELEASE;
			end else if (r < 75) begin
				c_op = OP_TICK;
				if ($urandom_range(11) == 0)
					tick_run = $urandom_range(30, 5);
			end else begin
				c_op = OP_READ;
			end
			k = 8'($urandom);
			if (c_op == OP_PLAY) begin
				if ($urandom_range(1))
					k = 8'($urandom_range(7));
				recent_keys[key_ptr] = k;
				key_ptr = (key_ptr + 1) % 8;
			end else if (c_op == OP_RELEASE && $urandom_range(9) < 7) begin
				k = recent_keys[$urandom_range(7)];
			end
			send_word(c_op, 16'($urandom), 16'($urandom), 16'($urandom), k,
				2'($urandom_range(3)), 1'b0, '0);
			// Now and then drain fully before the next word.
			if ($urandom_range(149) == 0)
				settle();
			else
				hold_off(pct);
		end
	endtask

	initial begin
		int idle_pct [PHASES];
		idle_pct = '{0, 61, 0, 37, 61};
		for (int i = 0; i < VOICES; i++)
			voice_bank[i] = '0;
		for (int i = 0; i < 8; i++)
			recent_keys[i] = 8'(i);

		// Directed rows, all at the reset rates (attack 12, release 3).
		// Empty row after reset.
		dir_table.push_back('{OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd0,
			1'b1, quiet(3'd0)});
		dir_table.push_back('{OP_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3,
			1'b1, quiet(3'd0)});
		// Fill all four slots, the first two with extreme words.
		dir_table.push_back('{OP_PLAY, 16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 2'd0,
			1'b1, quiet(3'd1)});
		dir_table.push_back('{OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd0,
			1'b1, seen(16'hFFFF, 16'h0000, 16'hFFFF, 8'h01, 1'b1, 8'hFF, 3'd1)});
		dir_table.push_back('{OP_PLAY, 16'h0000, 16'hFFFF, 16'h0000, 8'h00, 2'd3,
			1'b1, quiet(3'd2)});
		dir_table.push_back('{OP_PLAY, 16'hA5A5, 16'h5A5A, 16'h1234, 8'h80, 2'd1,
			1'b1, quiet(3'd3)});
		dir_table.push_back('{OP_PLAY, 16'h0001, 16'h0002, 16'h0003, 8'h7F, 2'd2,
			1'b1, quiet(3'd4)});
		// Row full: slot 0 drops out and the new voice lands last.
		dir_table.push_back('{OP_PLAY, 16'h0004, 16'h0005, 16'h0006, 8'h55, 2'd0,
			1'b1, quiet(3'd4)});
		dir_table.push_back('{OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd0,
			1'b1, seen(16'h0000, 16'hFFFF, 16'h0000, 8'h01, 1'b1, 8'h00, 3'd4)});
		dir_table.push_back('{OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd3,
			1'b1, seen(16'h0004, 16'h0005, 16'h0006, 8'h01, 1'b1, 8'h55, 3'd4)});
		dir_table.push_back('{OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd0,
			1'b1, quiet(3'd4)});
		// Release of a key nobody holds changes nothing.
		dir_table.push_back('{OP_RELEASE, 16'h0000, 16'h0000, 16'h0000, 8'h33, 2'd0,
			1'b1, quiet(3'd4)});
		dir_table.push_back('{OP_RELEASE, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd0,
			1'b1, quiet(3'd4)});
		dir_table.push_back('{OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd0,
			1'b1, quiet(3'd4)});
		// Released slot decays 13 -> 12, held ones climb 13 -> 25.
		dir_table.push_back('{OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd0,
			1'b1, seen(16'h0000, 16'hFFFF, 16'h0000, 8'h0C, 1'b0, 8'h00, 3'd4)});
		dir_table.push_back('{OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd1,
			1'b1, seen(16'hA5A5, 16'h5A5A, 16'h1234, 8'h19, 1'b1, 8'h80, 3'd4)});
		// From here the predictor decides.
		dir_table.push_back('{OP_RELEASE, 16'h0000, 16'h0000, 16'h0000, 8'h80, 2'd0,
			1'b0, '0});
		dir_table.push_back('{OP_PLAY, 16'hF0F0, 16'h0F0F, 16'h8001, 8'hAA, 2'd0,
			1'b0, '0});
		dir_table.push_back('{OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd2,
			1'b0, '0});
		dir_table.push_back('{OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd3,
			1'b0, '0});
		dir_table.push_back('{OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd0,
			1'b0, '0});
		dir_table.push_back('{OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd1,
			1'b0, '0});
		dir_table.push_back('{OP_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2'd0,
			1'b0, '0});

		// Hold reset, then release it once.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table back to back.
		foreach (dir_table[i])
			send_word(dir_table[i].op, dir_table[i].pitch_a, dir_table[i].pitch_b,
				dir_table[i].pitch_c, dir_table[i].key, dir_table[i].slot,
				dir_table[i].pinned, dir_table[i].want);

		// Random phases; rates change only once the block has gone quiet.
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				settle();
				case (p)
					1: write_rates(8'd255, 8'd255);
					2: write_rates(8'd0, 8'd0);
					3: write_rates(8'($urandom_range(254, 1)), 8'($urandom_range(254, 1)));
					default: write_rates(8'd1, 8'd254);
				endcase
			end
			run_random(RAND_WORDS, idle_pct[p]);
		end

		// Drain, let the block go idle, then judge.
		settle();
		repeat (3) @(posedge clk);
		if (fails == 0 && reports_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
